// ===== design/lmw_pkg.sv =====
`default_nettype none

package lmw_pkg;

   // Field widths fixed by the interface of the block.
   localparam int IN_PIXEL_BITS  = 8;
   localparam int OUT_ROW_BITS   = 12;
   localparam int OUT_COL_BITS   = 12;
   localparam int RADIUS_BITS    = 2;
   localparam int SIZE_BITS      = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_RADIUS = 3;
   localparam int DEF_PIXEL_BITS = 8;

   // Register values after reset.
   localparam logic [RADIUS_BITS-1:0] RESET_RADIUS = RADIUS_BITS'(1);
   localparam logic [SIZE_BITS-1:0]   RESET_WIDTH  = SIZE_BITS'(4096);
   localparam logic [SIZE_BITS-1:0]   RESET_HEIGHT = SIZE_BITS'(4096);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_RADIUS = 2'd0,
      CSR_IMAGE_WIDTH   = 2'd1,
      CSR_IMAGE_HEIGHT  = 2'd2
   } csr_index_type;

   // Per-item bookkeeping that travels with a pixel down the pipeline.
   typedef struct packed {
      logic                    emit;
      logic                    last;
      logic [OUT_ROW_BITS-1:0] center_row;
      logic [OUT_COL_BITS-1:0] center_col;
   } meta_type;

endpackage

`default_nettype wire

// ===== design/lmw_if.sv =====
`default_nettype none

interface lmw_req_if;
   logic                               valid;
   logic                               ready;
   logic [lmw_pkg::IN_PIXEL_BITS-1:0] pixel;
   logic                               frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lmw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lmw_pkg::OUT_ROW_BITS-1:0]  center_row;
   logic [lmw_pkg::OUT_COL_BITS-1:0]  center_col;
   logic                               is_max;
   logic [lmw_pkg::IN_PIXEL_BITS-1:0] max_value;
   logic                               frame_last;

   modport source (output valid, output center_row, output center_col, output is_max,
                   output max_value, output frame_last, input ready);
   modport sink   (input valid, input center_row, input center_col, input is_max,
                   input max_value, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== design/lmw_position.sv =====
`default_nettype none

module lmw_position #(
   parameter int MAX_WIDTH  = lmw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lmw_pkg::DEF_MAX_HEIGHT,
   parameter int LINES      = 2 * lmw_pkg::DEF_MAX_RADIUS,
   parameter int RAD_BITS   = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             frame_start,
   input  wire logic [lmw_pkg::SIZE_BITS-1:0]   image_width,
   input  wire logic [lmw_pkg::SIZE_BITS-1:0]   image_height,
   input  wire logic [RAD_BITS-1:0]             rad,
   output      logic [$clog2(MAX_WIDTH)-1:0]    col_addr,
   output      logic [$clog2(LINES)-1:0]        slot,
   output      lmw_pkg::meta_type               meta
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int SLOT_BITS = $clog2(LINES);
   localparam int CMPW = ((COL_BITS + 1) > lmw_pkg::SIZE_BITS) ? COL_BITS + 1
                                                                : lmw_pkg::SIZE_BITS;
   localparam int CMPH = ((ROW_BITS + 1) > lmw_pkg::SIZE_BITS) ? ROW_BITS + 1
                                                                : lmw_pkg::SIZE_BITS;

   logic [COL_BITS-1:0]  col_ff, col_in, c0, ccol;
   logic [ROW_BITS-1:0]  row_ff, row_in, r0, crow;
   logic [SLOT_BITS-1:0] slot_ff, slot_in, s0;
   logic [CMPW-1:0]      w_eff, c_next;
   logic [CMPH-1:0]      h_eff, r_next;
   logic [RAD_BITS:0]    two_rad;

   always_comb begin
      if (image_width == '0) begin
         w_eff = CMPW'(1);
      end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = CMPW'(image_width);
      end
      if (image_height == '0) begin
         h_eff = CMPH'(1);
      end else if (CMPH'(image_height) > CMPH'(MAX_HEIGHT)) begin
         h_eff = CMPH'(MAX_HEIGHT);
      end else begin
         h_eff = CMPH'(image_height);
      end

      // A frame start mark puts this pixel at the origin.
      r0 = frame_start ? '0 : row_ff;
      c0 = frame_start ? '0 : col_ff;
      s0 = frame_start ? '0 : slot_ff;

      two_rad = {rad, 1'b0};
      crow    = r0 - ROW_BITS'(rad);
      ccol    = c0 - COL_BITS'(rad);

      meta.emit = (32'(r0) >= 32'(two_rad)) && (32'(c0) >= 32'(two_rad));
      meta.last = (CMPH'(r0) == h_eff - CMPH'(1)) && (CMPW'(c0) == w_eff - CMPW'(1));
      meta.center_row = lmw_pkg::OUT_ROW_BITS'(crow);
      meta.center_col = lmw_pkg::OUT_COL_BITS'(ccol);

      c_next = CMPW'(c0) + CMPW'(1);
      r_next = CMPH'(r0) + CMPH'(1);
      if (c_next >= w_eff) begin
         col_in = '0;
         if (r_next >= h_eff) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = r_next[ROW_BITS-1:0];
            slot_in = (s0 == SLOT_BITS'(LINES - 1)) ? '0 : s0 + SLOT_BITS'(1);
         end
      end else begin
         col_in  = c_next[COL_BITS-1:0];
         row_in  = r0;
         slot_in = s0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (advance) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   assign col_addr = c0;
   assign slot     = s0;

endmodule

`default_nettype wire

// ===== design/lmw_line_store.sv =====
`default_nettype none

module lmw_line_store #(
   parameter int MAX_WIDTH = lmw_pkg::DEF_MAX_WIDTH,
   parameter int LINES     = 2 * lmw_pkg::DEF_MAX_RADIUS,
   parameter int PB        = lmw_pkg::DEF_PIXEL_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  addr,
   input  wire logic [$clog2(LINES)-1:0]      slot,
   input  wire logic [PB-1:0]                 wdata,
   output      logic [PB-1:0]                 column [LINES]
);

   localparam int SW = $clog2(LINES);

   logic [PB-1:0] rd_data [LINES];
   logic [SW-1:0] slot_ff;

   // One row buffer per slot; all read the old word at the address that the current slot's row writes.
   for (genvar s = 0; s < LINES; s++) begin : g_row
      logic [PB-1:0] mem [MAX_WIDTH];
      logic [PB-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (enable) begin
            rd_ff <= mem[addr];
            if (slot == SW'(s)) begin
               mem[addr] <= wdata;
            end
         end
      end

      assign rd_data[s] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         slot_ff <= slot;
      end
   end

   // Reorder so that entry 0 is the oldest row and entry LINES-1 the newest.
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         if (32'(slot_ff) + 32'(k) >= 32'(LINES)) begin
            column[k] = rd_data[SW'(32'(slot_ff) + 32'(k) - 32'(LINES))];
         end else begin
            column[k] = rd_data[SW'(32'(slot_ff) + 32'(k))];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/lmw_window.sv =====
`default_nettype none

module lmw_window #(
   parameter int LINES    = 2 * lmw_pkg::DEF_MAX_RADIUS,
   parameter int PB       = lmw_pkg::DEF_PIXEL_BITS,
   parameter int RAD_BITS = 2
) (
   input  wire logic                clock,
   input  wire logic                shift,
   input  wire logic [PB-1:0]       column [LINES+1],
   input  wire logic [RAD_BITS-1:0] rad,
   output      logic                is_max,
   output      logic [PB-1:0]       center_value
);

   localparam int SPAN = LINES + 1;
   localparam int IW   = $clog2(SPAN);

   logic [PB-1:0] window_ff [SPAN][SPAN];
   logic [IW-1:0] ctr;
   logic [IW-1:0] base;

   always_ff @(posedge clock) begin
      if (shift) begin
         for (int k = 0; k < SPAN; k++) begin
            for (int m = 0; m < SPAN - 1; m++) begin
               window_ff[k][m] <= window_ff[k][m+1];
            end
            window_ff[k][SPAN-1] <= column[k];
         end
      end
   end

   // The active square sits in the bottom-right corner of the window.
   always_comb begin
      ctr          = IW'(LINES) - IW'(rad);
      base         = IW'(LINES) - IW'({rad, 1'b0});
      center_value = window_ff[ctr][ctr];
      is_max       = 1'b1;
      for (int k = 0; k < SPAN; k++) begin
         for (int m = 0; m < SPAN; m++) begin
            if (IW'(k) >= base && IW'(m) >= base && !(IW'(k) == ctr && IW'(m) == ctr)
                && window_ff[k][m] >= center_value) begin
               is_max = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/local_max_window_2d.sv =====
// Pipeline: an accepted pixel goes through the line store read, the window shift and
// the compare into the result register.
// Throughput: one pixel per cycle unless the output stalls; each line store row reads
// and only the current slot's row writes per accepted pixel; all window compares run in parallel.
// Reset: synchronous, active high; clears position counters, pipeline valids and
// loads the registers with radius 1, width 4096 and height 4096.
`default_nettype none

module local_max_window_2d #(
   parameter int MAX_WIDTH  = lmw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lmw_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = lmw_pkg::DEF_MAX_RADIUS,
   parameter int PIXEL_BITS = lmw_pkg::DEF_PIXEL_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lmw_req_if.sink                                   req_ch,
   lmw_rsp_if.source                                 rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [lmw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lmw_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int LINES     = 2 * MAX_RADIUS;
   localparam int PB        = (PIXEL_BITS < lmw_pkg::IN_PIXEL_BITS) ? PIXEL_BITS
                                                                    : lmw_pkg::IN_PIXEL_BITS;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int SLOT_BITS = $clog2(LINES);
   localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);

   // Configuration registers.
   logic [lmw_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [lmw_pkg::SIZE_BITS-1:0]   width_ff;
   logic [lmw_pkg::SIZE_BITS-1:0]   height_ff;
   logic [RAD_BITS-1:0]             rad;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= lmw_pkg::RESET_RADIUS;
         width_ff  <= lmw_pkg::RESET_WIDTH;
         height_ff <= lmw_pkg::RESET_HEIGHT;
      end else if (csr_we) begin
         unique case (lmw_pkg::csr_index_type'(csr_index))
            lmw_pkg::CSR_WINDOW_RADIUS: begin
               radius_ff <= csr_wdata[lmw_pkg::RADIUS_BITS-1:0];
            end
            lmw_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[lmw_pkg::SIZE_BITS-1:0];
            end
            lmw_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[lmw_pkg::SIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (radius_ff == '0) begin
         rad = RAD_BITS'(1);
      end else if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         rad = RAD_BITS'(MAX_RADIUS);
      end else begin
         rad = RAD_BITS'(radius_ff);
      end
   end

   // Pipeline control.
   logic accept, req_ready, s1_adv, s2_adv, rsp_load;
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in, rsp_valid_ff, rsp_valid_in;
   lmw_pkg::meta_type s1_meta_ff, s2_meta_ff, pos_meta;
   logic [PB-1:0] pix, s1_pix_ff;

   logic [COL_BITS-1:0]  col_addr;
   logic [SLOT_BITS-1:0] slot;
   logic [PB-1:0]        store_col [LINES];
   logic [PB-1:0]        win_col [LINES+1];
   logic                 win_is_max;
   logic [PB-1:0]        center_value;

   logic [lmw_pkg::OUT_ROW_BITS-1:0]  rsp_row_ff;
   logic [lmw_pkg::OUT_COL_BITS-1:0]  rsp_col_ff;
   logic                              rsp_ismax_ff, rsp_last_ff;
   logic [lmw_pkg::IN_PIXEL_BITS-1:0] rsp_value_ff, rsp_value_in;

   always_comb begin
      // An item that produces no result leaves stage 2 without waiting for the output.
      s2_adv    = s2_valid_ff && (!s2_meta_ff.emit || !rsp_valid_ff || rsp_ch.ready);
      s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
      req_ready = !s1_valid_ff || s1_adv;
      accept    = req_ch.valid && req_ready;
      rsp_load  = s2_adv && s2_meta_ff.emit;

      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      s2_valid_in  = s1_adv || (s2_valid_ff && !s2_adv);
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

      pix          = req_ch.pixel[PB-1:0];
      rsp_value_in = win_is_max ? lmw_pkg::IN_PIXEL_BITS'(center_value) : '0;

      for (int k = 0; k < LINES; k++) begin
         win_col[k] = store_col[k];
      end
      win_col[LINES] = s1_pix_ff;
   end

   lmw_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .LINES      (LINES),
      .RAD_BITS   (RAD_BITS)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_start  (req_ch.frame_start),
      .image_width  (width_ff),
      .image_height (height_ff),
      .rad          (rad),
      .col_addr     (col_addr),
      .slot         (slot),
      .meta         (pos_meta)
   );

   lmw_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .LINES     (LINES),
      .PB        (PB)
   ) u_line_store (
      .clock  (clock),
      .enable (accept),
      .addr   (col_addr),
      .slot   (slot),
      .wdata  (pix),
      .column (store_col)
   );

   lmw_window #(
      .LINES    (LINES),
      .PB       (PB),
      .RAD_BITS (RAD_BITS)
   ) u_window (
      .clock        (clock),
      .shift        (s1_adv),
      .column       (win_col),
      .rad          (rad),
      .is_max       (win_is_max),
      .center_value (center_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= pos_meta;
         s1_pix_ff  <= pix;
      end
      if (s1_adv) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (rsp_load) begin
         rsp_row_ff   <= s2_meta_ff.center_row;
         rsp_col_ff   <= s2_meta_ff.center_col;
         rsp_ismax_ff <= win_is_max;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= s2_meta_ff.last;
      end
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.center_row = rsp_row_ff;
   assign rsp_ch.center_col = rsp_col_ff;
   assign rsp_ch.is_max     = rsp_ismax_ff;
   assign rsp_ch.max_value  = rsp_value_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not reach the read stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_meta_ff)))
      else $error("stalled item in the read stage was lost or changed");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ismax_ff) |-> (rsp_value_ff == '0))
      else $error("result value is nonzero for a center that is not a maximum");

   a_load_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_meta_ff.emit))
      else $error("result loaded without an emitting item in the compare stage");

endmodule

`default_nettype wire

// ===== verif/tb_local_max_window_2d.sv =====
module tb_local_max_window_2d;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS_HELD = 2 * lmw_pkg::DEF_MAX_RADIUS;
   localparam int SPAN      = 2 * lmw_pkg::DEF_MAX_RADIUS + 1;
   localparam int LONG_CAP  = 30;
   localparam int BULK_CAP  = 2;

   typedef struct packed {
      logic [lmw_pkg::IN_PIXEL_BITS-1:0] pixel;
      logic                              frame_start;
   } pixel_item_type;

   typedef struct packed {
      logic [lmw_pkg::OUT_ROW_BITS-1:0]  row;
      logic [lmw_pkg::OUT_COL_BITS-1:0]  col;
      logic                              is_max;
      logic [lmw_pkg::IN_PIXEL_BITS-1:0] value;
      logic                              last;
   } center_verdict_type;

   typedef enum int {TEX_UNIFORM, TEX_LOW, TEX_SPARSE, TEX_HIGH} texture_type;

   // Opening frame, radius 1, width 7: a lone 255 peak, a 200 plateau, a small
   // strict peak of 10, and a start of the next row with 255 ties.
   localparam logic [7:0] OPENING_PIXELS [25] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd255, 8'd200, 8'd200, 8'd9, 8'd10, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd0, 8'd1,
      8'd255, 8'd255, 8'd254, 8'd0
   };

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   lmw_pkg::csr_index_type            csr_index;
   logic [lmw_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   lmw_req_if req_ch ();
   lmw_rsp_if rsp_ch ();

   local_max_window_2d i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: its own line store, window and position counters.
   logic [lmw_pkg::IN_PIXEL_BITS-1:0] held_rows [ROWS_HELD][lmw_pkg::DEF_MAX_WIDTH];
   logic [lmw_pkg::IN_PIXEL_BITS-1:0] neighborhood [SPAN][SPAN];
   int unsigned                       row_pos;
   int unsigned                       col_pos;
   logic [lmw_pkg::RADIUS_BITS-1:0]   set_radius;
   logic [lmw_pkg::SIZE_BITS-1:0]     set_width;
   logic [lmw_pkg::SIZE_BITS-1:0]     set_height;

   pixel_item_type     pixel_feed [$];
   center_verdict_type awaited_verdicts [$];

   int unsigned hold_off;
   int unsigned stall_left;
   int unsigned gap_cap;
   int unsigned stall_cap;
   logic        sender_steady;
   logic        receiver_steady;

   int unsigned failures;
   int unsigned pixels_taken;
   int unsigned verdicts_checked;
   int unsigned peaks_found;
   int unsigned frames_closed;
   int unsigned settings_tried;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("local_max_window_2d verification failed");
      $finish;
   end

   function automatic int unsigned pick_pause(int unsigned cap);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return 0;
      if (roll < 96) return $urandom_range(1, (cap < 3) ? cap : 3);
      return $urandom_range(1, cap);
   endfunction

   function automatic logic [lmw_pkg::IN_PIXEL_BITS-1:0] draw_pixel(texture_type tex);
      case (tex)
         TEX_UNIFORM: return lmw_pkg::IN_PIXEL_BITS'($urandom_range(255));
         TEX_LOW:     return lmw_pkg::IN_PIXEL_BITS'($urandom_range(3));
         TEX_SPARSE: begin
            if ($urandom_range(9) == 0) return lmw_pkg::IN_PIXEL_BITS'($urandom_range(255));
            return lmw_pkg::IN_PIXEL_BITS'($urandom_range(7));
         end
         default:     return lmw_pkg::IN_PIXEL_BITS'($urandom_range(255, 250));
      endcase
   endfunction

   function automatic texture_type pick_texture();
      if ($urandom_range(3) == 0) return TEX_UNIFORM;
      return texture_type'($urandom_range(3));
   endfunction

   task automatic note_failure(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
   endtask

   // Advance the predicted block by one accepted pixel.
   task automatic judge_pixel(logic [lmw_pkg::IN_PIXEL_BITS-1:0] pix, logic fs);
      int unsigned        w, h, rad, r, c, slot, base, ctr;
      int                 k, m;
      logic [7:0]         cv;
      logic               peak;
      center_verdict_type v;
      w   = (set_width == 0) ? 1 :
            ((set_width > lmw_pkg::DEF_MAX_WIDTH) ? lmw_pkg::DEF_MAX_WIDTH : set_width);
      h   = (set_height == 0) ? 1 :
            ((set_height > lmw_pkg::DEF_MAX_HEIGHT) ? lmw_pkg::DEF_MAX_HEIGHT : set_height);
      rad = (set_radius == 0) ? 1 :
            ((set_radius > lmw_pkg::DEF_MAX_RADIUS) ? lmw_pkg::DEF_MAX_RADIUS : set_radius);
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end
      r    = row_pos;
      c    = col_pos;
      slot = r % ROWS_HELD;
      for (k = 0; k < SPAN; k++) begin
         for (m = 0; m < SPAN - 1; m++) neighborhood[k][m] = neighborhood[k][m+1];
      end
      // The current row's slot still holds the oldest stored row.
      for (k = 0; k < ROWS_HELD; k++) begin
         neighborhood[k][SPAN-1] =
            held_rows[(slot + k) % ROWS_HELD][c % lmw_pkg::DEF_MAX_WIDTH];
      end
      neighborhood[SPAN-1][SPAN-1]                = pix;
      held_rows[slot][c % lmw_pkg::DEF_MAX_WIDTH] = pix;
      if (r >= 2 * rad && c >= 2 * rad) begin
         base = ROWS_HELD - 2 * rad;
         ctr  = ROWS_HELD - rad;
         cv   = neighborhood[ctr][ctr];
         peak = 1'b1;
         for (k = base; k < SPAN; k++) begin
            for (m = base; m < SPAN; m++) begin
               if (!(k == ctr && m == ctr) && neighborhood[k][m] >= cv) peak = 1'b0;
            end
         end
         v.row    = lmw_pkg::OUT_ROW_BITS'(r - rad);
         v.col    = lmw_pkg::OUT_COL_BITS'(c - rad);
         v.is_max = peak;
         v.value  = peak ? cv : '0;
         v.last   = (r == h - 1) && (c == w - 1);
         awaited_verdicts.push_back(v);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   always @(posedge clock) begin : feed_pixels
      pixel_item_type item;
      if (reset) begin
         req_ch.valid  <= 1'b0;
         hold_off      <= 0;
         sender_steady <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            judge_pixel(req_ch.pixel, req_ch.frame_start);
            pixels_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (hold_off != 0) begin
               req_ch.valid <= 1'b0;
               hold_off     <= hold_off - 1;
            end else if (pixel_feed.size() != 0) begin
               item               = pixel_feed.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.pixel       <= item.pixel;
               req_ch.frame_start <= item.frame_start;
               hold_off           <= sender_steady ? 0 : pick_pause(gap_cap);
               if ($urandom_range(199) == 0) sender_steady <= !sender_steady;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_verdicts
      center_verdict_type want;
      if (reset) begin
         rsp_ch.ready    <= 1'b0;
         stall_left      <= 0;
         receiver_steady <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            verdicts_checked++;
            if (rsp_ch.is_max) peaks_found++;
            if (rsp_ch.frame_last) frames_closed++;
            if (awaited_verdicts.size() == 0) begin
               note_failure($sformatf("unexpected result for center (%0d,%0d)",
                                      rsp_ch.center_row, rsp_ch.center_col));
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_ch.center_row !== want.row || rsp_ch.center_col !== want.col ||
                   rsp_ch.is_max !== want.is_max || rsp_ch.max_value !== want.value ||
                   rsp_ch.frame_last !== want.last) begin
                  note_failure($sformatf(
                     "expected row %0d col %0d max %b value %0d last %b, got %0d %0d %b %0d %b",
                     want.row, want.col, want.is_max, want.value, want.last,
                     rsp_ch.center_row, rsp_ch.center_col, rsp_ch.is_max,
                     rsp_ch.max_value, rsp_ch.frame_last));
               end
            end
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!receiver_steady && $urandom_range(3) == 0) stall_left <= pick_pause(stall_cap);
            if ($urandom_range(199) == 0) receiver_steady <= !receiver_steady;
         end
      end
   end

   task automatic write_csr(lmw_pkg::csr_index_type idx,
                            logic [lmw_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lmw_pkg::CSR_WINDOW_RADIUS: set_radius = data[lmw_pkg::RADIUS_BITS-1:0];
         lmw_pkg::CSR_IMAGE_WIDTH:   set_width  = data[lmw_pkg::SIZE_BITS-1:0];
         lmw_pkg::CSR_IMAGE_HEIGHT:  set_height = data[lmw_pkg::SIZE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_window(int unsigned rad, int unsigned w, int unsigned h);
      write_csr(lmw_pkg::CSR_WINDOW_RADIUS, lmw_pkg::CSR_DATA_BITS'(rad));
      write_csr(lmw_pkg::CSR_IMAGE_WIDTH, lmw_pkg::CSR_DATA_BITS'(w));
      write_csr(lmw_pkg::CSR_IMAGE_HEIGHT, lmw_pkg::CSR_DATA_BITS'(h));
      settings_tried++;
   endtask

   // A rare stray frame start inside a frame restarts the position counters.
   task automatic queue_frame(int unsigned count, logic marked, texture_type tex);
      pixel_item_type item;
      for (int unsigned i = 0; i < count; i++) begin
         item.pixel       = draw_pixel(tex);
         item.frame_start = (i == 0) ? marked : ($urandom_range(499) == 0);
         pixel_feed.push_back(item);
      end
   endtask

   // Hold the sender until the block has gone quiet.
   task automatic drain();
      while (pixel_feed.size() != 0 || req_ch.valid || awaited_verdicts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The leading part of a frame with a large size setting.
   task automatic run_bulk_frame(int unsigned rad, int unsigned w, int unsigned h,
                                 int unsigned count);
      gap_cap   = BULK_CAP;
      stall_cap = BULK_CAP;
      program_window(rad, w, h);
      queue_frame(count, 1'b1, TEX_UNIFORM);
      drain();
      gap_cap   = LONG_CAP;
      stall_cap = LONG_CAP;
   endtask

   initial begin : stimulus
      pixel_item_type item;
      int unsigned    rad, w, h, n, budget, roll;
      logic           marked;
      csr_we             = 1'b0;
      csr_index          = lmw_pkg::CSR_WINDOW_RADIUS;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.pixel       = '0;
      req_ch.frame_start = 1'b0;
      rsp_ch.ready       = 1'b0;
      for (int k = 0; k < ROWS_HELD; k++) begin
         for (int m = 0; m < lmw_pkg::DEF_MAX_WIDTH; m++) held_rows[k][m] = '0;
      end
      for (int k = 0; k < SPAN; k++) begin
         for (int m = 0; m < SPAN; m++) neighborhood[k][m] = '0;
      end
      row_pos          = 0;
      col_pos          = 0;
      set_radius       = lmw_pkg::RESET_RADIUS;
      set_width        = lmw_pkg::RESET_WIDTH;
      set_height       = lmw_pkg::RESET_HEIGHT;
      gap_cap          = LONG_CAP;
      stall_cap        = LONG_CAP;
      failures         = 0;
      pixels_taken     = 0;
      verdicts_checked = 0;
      peaks_found      = 0;
      frames_closed    = 0;
      settings_tried   = 0;
      reset            = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      program_window(1, 7, 7);
      for (int i = 0; i < 25; i++) begin
         item.pixel       = OPENING_PIXELS[i];
         item.frame_start = (i == 0);
         pixel_feed.push_back(item);
      end
      // Finish that frame, then run one more without a frame start mark.
      queue_frame(24, 1'b0, TEX_SPARSE);
      queue_frame(49, 1'b0, TEX_LOW);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         rad = (ph == 0) ? 3 : $urandom_range(1, 3);
         w   = (ph == 0) ? 7 : $urandom_range(7, 20);
         h   = (ph == 0) ? 7 : $urandom_range(7, 14);
         program_window(rad, w, h);
         // A size change is always followed by a marked frame.
         queue_frame(w * h, 1'b1, pick_texture());
         budget = w * h;
         while (budget < 135) begin
            roll   = $urandom_range(99);
            n      = (roll < 90) ? w * h : $urandom_range(1, w * h - 1);
            marked = !(roll >= 80 && roll < 90);
            queue_frame(n, marked, pick_texture());
            budget += n;
         end
         drain();
         if (ph == 2) run_bulk_frame(3, 4096, 7, 200);
         if (ph == 5) run_bulk_frame(2, 7, 4096, 140);
      end
      drain();

      $display("Streamed %0d pixels under %0d window settings, radius 1 to 3, sizes 7 to 4096.",
               pixels_taken, settings_tried);
      $display("Checked %0d center results, %0d local maxima, %0d frame ends.",
               verdicts_checked, peaks_found, frames_closed);
      if (failures == 0 && awaited_verdicts.size() == 0) begin
         $display("local_max_window_2d verification clean");
      end else begin
         $display("local_max_window_2d verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/lmw_pkg.sv
design/lmw_if.sv
design/lmw_position.sv
design/lmw_line_store.sv
design/lmw_window.sv
design/local_max_window_2d.sv
verif/tb_local_max_window_2d.sv
